/* sv/dci_pkg.sv */
`timescale 1ns / 1ps

package dci_pkg;

   // Fixed geometry of the sample stream
   localparam int SAMPLE_BITS = 16;
   localparam int MAX_WINDOW  = 65536;

   // Derived widths
   localparam int ABS_BITS  = SAMPLE_BITS;
   localparam int SSQ_BITS  = 2 * SAMPLE_BITS + 2;
   localparam int ROOT_BITS = SAMPLE_BITS + 1;
   localparam int SQRT_STEPS = SSQ_BITS / 2;
   localparam int DVD_BITS  = 65;
   localparam int DVS_BITS  = 47;
   localparam int MAG_BITS  = 33;
   localparam int CNT_BITS  = 17;

   localparam logic [CNT_BITS-1:0] CNT_CAP =
      (MAX_WINDOW < 131071) ? CNT_BITS'(MAX_WINDOW) : 17'h1FFFF;
   localparam logic [MAG_BITS-1:0] MAG_MAX = '1;
   localparam logic [DVS_BITS-1:0] SQ_MAX  = '1;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SHORT = 2'd1;
   localparam logic [1:0] ST_FEW   = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_SENS = 2'd0;
   localparam logic [1:0] REG_THR  = 2'd1;
   localparam logic [1:0] REG_MIN  = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] accel_x;
      logic signed [SAMPLE_BITS-1:0] accel_y;
      logic signed [SAMPLE_BITS-1:0] accel_z;
      logic                          sample_valid;
      logic                          last_sample;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [16:0] valid_count;
      logic [16:0] above_count;
      logic [31:0] gravity_g;
      logic [31:0] comfort_index;
      logic        dci_valid;
   } rsp_type;

   typedef struct packed {
      logic [15:0] sensitivity_lsb_per_g;
      logic [14:0] threshold_raw;
      logic [15:0] min_samples;
   } cfg_type;

   // Classified sample handed from front to back
   typedef struct packed {
      logic [SSQ_BITS-1:0] sum_sq;
      logic [DVS_BITS-1:0] x_sq;
      logic                valid;
      logic                above;
      logic                last;
   } entry_type;

   // Q16.16 quotient saturated to 32 bits; zero divisor saturates
   function automatic logic [31:0] q_sat(input logic [DVD_BITS-1:0] q,
                                         input logic [DVS_BITS-1:0] d);
      logic [31:0] r;
      if (d == '0 || q[DVD_BITS-1:32] != '0) begin
         r = '1;
      end else begin
         r = q[31:0];
      end
      return r;
   endfunction

endpackage

/* sv/dynamic_comfort_index_window.sv */
`timescale 1ns / 1ps

// Comfort index over windows of three-axis accelerometer samples.
// Input side is a queue: drive req_data and push; a transfer happens when
// push is high and full is low. The sample with last_sample set closes the
// window and yields one result.
// Result side is a queue: while empty is low the oldest result is on
// rsp_data; it transfers when pop is high. A stalled receiver holds the
// result; the block keeps taking samples until its two-entry queue fills.
// A valid sample holds the back end for the digit-serial square root before
// the next sample is drawn from the queue; an invalid one skips it. Closing
// a window runs the bit-serial divider once for gravity and once for the
// comfort index when the index is valid, once without the index, and not
// at all on a short or sparse window.
// Registers sit on an APB-style port at byte addresses 0, 4 and 8:
// sensitivity, threshold, minimum sample count. Write them only while idle.
// Reset (synchronous) restores register defaults, clears the window and
// drops any pending result.
module dynamic_comfort_index_window (
   input  logic             clock,
   input  logic             reset,
   input  dci_pkg::req_type req_data,
   input  logic             push,
   output logic             full,
   output dci_pkg::rsp_type rsp_data,
   output logic             empty,
   input  logic             pop,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import dci_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   entry_type f_entry, q_entry;
   logic      q_full, q_empty, q_pop;
   logic      wr_fire;

   assign pready  = 1'b1;
   assign wr_fire = psel && penable && pwrite && pready;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         unique case (paddr[3:2])
            REG_SENS: cfg_in.sensitivity_lsb_per_g = pwdata[15:0];
            REG_THR:  cfg_in.threshold_raw         = pwdata[14:0];
            REG_MIN:  cfg_in.min_samples           = pwdata[15:0];
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensitivity_lsb_per_g <= 16'd16384;
         cfg_ff.threshold_raw         <= 15'd16384;
         cfg_ff.min_samples           <= 16'd10;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register readback
   always_comb begin
      unique case (paddr[3:2])
         REG_SENS: prdata = 32'(cfg_ff.sensitivity_lsb_per_g);
         REG_THR:  prdata = 32'(cfg_ff.threshold_raw);
         REG_MIN:  prdata = 32'(cfg_ff.min_samples);
         default:  prdata = '0;
      endcase
   end

   assign full = q_full;

   dci_front u_front (
      .req_data  (req_data),
      .threshold (cfg_ff.threshold_raw),
      .entry     (f_entry)
   );

   dci_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (f_entry),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .rd_data (q_entry),
      .q_empty (q_empty)
   );

   dci_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .entry    (q_entry),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_data (rsp_data),
      .empty    (empty),
      .pop      (pop)
   );

`ifndef ASSERT_OFF
   // queue cannot be full and empty at once
   a_queue_state: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty)) else $error("queue full and empty together");

   // back end only draws from a nonempty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("pop from empty internal queue");

   // a comfort index is only flagged on a good window
   a_dci_ok: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.dci_valid) |-> rsp_data.status == ST_OK)
      else $error("dci_valid with bad status");

   // a bad window reports no gravity and no index
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.status != ST_OK) |->
         (rsp_data.gravity_g == '0 && rsp_data.comfort_index == '0))
      else $error("nonzero outputs on bad window");
`endif

endmodule

/* sv/dci_front.sv */
`timescale 1ns / 1ps

module dci_front (
   input  dci_pkg::req_type   req_data,
   input  logic [14:0]        threshold,
   output dci_pkg::entry_type entry
);
   import dci_pkg::*;

   logic [ABS_BITS-1:0]   ax, ay, az;
   logic [2*ABS_BITS-1:0] x2, y2, z2;

   // magnitude of a two's complement sample
   function automatic logic [ABS_BITS-1:0] mag_of(input logic [SAMPLE_BITS-1:0] v);
      logic [ABS_BITS-1:0] r;
      if (v[SAMPLE_BITS-1]) begin
         r = ABS_BITS'(~v) + ABS_BITS'(1);
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign ax = mag_of(req_data.accel_x);
   assign ay = mag_of(req_data.accel_y);
   assign az = mag_of(req_data.accel_z);

   // axis squares, three independent multipliers
   assign x2 = (2*ABS_BITS)'(ax) * (2*ABS_BITS)'(ax);
   assign y2 = (2*ABS_BITS)'(ay) * (2*ABS_BITS)'(ay);
   assign z2 = (2*ABS_BITS)'(az) * (2*ABS_BITS)'(az);

   assign entry.sum_sq = SSQ_BITS'(x2) + SSQ_BITS'(y2) + SSQ_BITS'(z2);
   assign entry.x_sq   = DVS_BITS'(x2);
   assign entry.valid  = req_data.sample_valid;
   assign entry.above  = 32'(ax) > 32'(threshold);
   assign entry.last   = req_data.last_sample;

endmodule

/* sv/dci_queue.sv */
`timescale 1ns / 1ps

module dci_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  dci_pkg::entry_type wr_data,
   output logic               q_full,
   input  logic               rd_en,
   output dci_pkg::entry_type rd_data,
   output logic               q_empty
);
   import dci_pkg::*;

   entry_type  mem_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_wr, do_rd;

   assign q_full  = count_ff == 2'd2;
   assign q_empty = count_ff == 2'd0;
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_data = mem_ff[rptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wptr_in  = do_wr ? !wptr_ff : wptr_ff;
      rptr_in  = do_rd ? !rptr_ff : rptr_ff;
      count_in = count_ff + 2'(do_wr) - 2'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

/* sv/dci_back.sv */
`timescale 1ns / 1ps

module dci_back (
   input  logic               clock,
   input  logic               reset,
   input  dci_pkg::cfg_type   cfg,
   input  dci_pkg::entry_type entry,
   input  logic               q_empty,
   output logic               q_pop,
   output dci_pkg::rsp_type   rsp_data,
   output logic               empty,
   input  logic               pop
);
   import dci_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SQRT = 3'd1;
   localparam logic [2:0] S_FIN  = 3'd2;
   localparam logic [2:0] S_GDIV = 3'd3;
   localparam logic [2:0] S_MUL1 = 3'd4;
   localparam logic [2:0] S_MUL2 = 3'd5;
   localparam logic [2:0] S_DDIV = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   localparam logic [6:0] SQRT_LAST = 7'(SQRT_STEPS - 1);
   localparam logic [6:0] DIV_LAST  = 7'(DVD_BITS - 1);

   logic [2:0]            state_ff, state_in;
   logic [CNT_BITS-1:0]   win_ff, win_in;
   logic [CNT_BITS-1:0]   valid_ff, valid_in;
   logic [CNT_BITS-1:0]   above_ff, above_in;
   logic [MAG_BITS-1:0]   mag_ff, mag_in;
   logic [DVS_BITS-1:0]   sq_ff, sq_in;
   logic                  last_ff, last_in;
   logic [6:0]            cnt_ff, cnt_in;
   logic [SSQ_BITS-1:0]   ssq_ff, ssq_in;
   logic [ROOT_BITS-1:0]  root_ff, root_in;
   logic [ROOT_BITS+1:0]  rem_ff, rem_in;
   logic [DVD_BITS-1:0]   dvd_ff, dvd_in;
   logic [DVS_BITS-1:0]   dvs_ff, dvs_in;
   logic [DVS_BITS-1:0]   drem_ff, drem_in;
   logic [31:0]           prod_ff, prod_in;
   logic [1:0]            status_ff, status_in;
   logic [31:0]           grav_ff, grav_in;
   logic [31:0]           dci_ff, dci_in;
   logic                  dvalid_ff, dvalid_in;
   rsp_type               out_ff, out_in;
   logic                  ovalid_ff, ovalid_in;

   logic [ROOT_BITS+1:0]  s_sh, s_trial, s_diff;
   logic                  s_ge;
   logic [DVS_BITS:0]     d_sh, d_diff;
   logic                  d_ge;
   logic [MAG_BITS:0]     mag_sum;
   logic [DVS_BITS:0]     sq_sum;
   logic [32:0]           vden;
   logic [48:0]           dnum;

   assign q_pop    = state_ff == S_IDLE && !q_empty;
   assign empty    = !ovalid_ff;
   assign rsp_data = out_ff;

   // one square-root digit per cycle
   assign s_sh    = {rem_ff[ROOT_BITS-1:0], ssq_ff[SSQ_BITS-1:SSQ_BITS-2]};
   assign s_trial = {root_ff, 2'b01};
   assign s_ge    = s_sh >= s_trial;
   assign s_diff  = s_sh - s_trial;

   // one quotient bit per cycle
   assign d_sh   = {drem_ff, dvd_ff[DVD_BITS-1]};
   assign d_ge   = d_sh >= {1'b0, dvs_ff};
   assign d_diff = d_sh - {1'b0, dvs_ff};

   assign mag_sum = {1'b0, mag_ff} + (MAG_BITS + 1)'(root_in);
   assign sq_sum  = {1'b0, sq_ff} + {1'b0, entry.x_sq};
   assign vden    = 33'(valid_ff) * 33'(cfg.sensitivity_lsb_per_g);
   assign dnum    = 49'(above_ff) * 49'(prod_ff);

   always_comb begin
      state_in  = state_ff;
      win_in    = win_ff;
      valid_in  = valid_ff;
      above_in  = above_ff;
      mag_in    = mag_ff;
      sq_in     = sq_ff;
      last_in   = last_ff;
      cnt_in    = cnt_ff;
      ssq_in    = ssq_ff;
      root_in   = root_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      drem_in   = drem_ff;
      prod_in   = prod_ff;
      status_in = status_ff;
      grav_in   = grav_ff;
      dci_in    = dci_ff;
      dvalid_in = dvalid_ff;
      out_in    = out_ff;
      ovalid_in = (ovalid_ff && pop) ? 1'b0 : ovalid_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               last_in = entry.last;
               if (win_ff < CNT_CAP) begin
                  win_in = win_ff + CNT_BITS'(1);
               end
               if (win_ff < CNT_CAP && entry.valid) begin
                  valid_in = valid_ff + CNT_BITS'(1);
                  if (entry.above) begin
                     above_in = above_ff + CNT_BITS'(1);
                     sq_in    = sq_sum > {1'b0, SQ_MAX} ? SQ_MAX : sq_sum[DVS_BITS-1:0];
                  end
                  ssq_in   = entry.sum_sq;
                  root_in  = '0;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = S_SQRT;
               end else if (entry.last) begin
                  state_in = S_FIN;
               end
            end
         end
         S_SQRT: begin
            ssq_in = ssq_ff << 2;
            cnt_in = cnt_ff + 7'd1;
            if (s_ge) begin
               rem_in  = s_diff;
               root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
            end else begin
               rem_in  = s_sh;
               root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
            end
            if (cnt_ff == SQRT_LAST) begin
               mag_in   = mag_sum > {1'b0, MAG_MAX} ? MAG_MAX : mag_sum[MAG_BITS-1:0];
               state_in = last_ff ? S_FIN : S_IDLE;
            end
         end
         S_FIN: begin
            if (win_ff < 17'(cfg.min_samples)) begin
               status_in = ST_SHORT;
            end else if (valid_ff < 17'(cfg.min_samples)) begin
               status_in = ST_FEW;
            end else begin
               status_in = ST_OK;
            end
            grav_in   = '0;
            dci_in    = '0;
            dvalid_in = 1'b0;
            if (win_ff >= 17'(cfg.min_samples) && valid_ff >= 17'(cfg.min_samples)) begin
               dvd_in   = {16'(0), mag_ff, 16'(0)};
               dvs_in   = DVS_BITS'(vden);
               drem_in  = '0;
               cnt_in   = '0;
               state_in = S_GDIV;
            end else begin
               state_in = S_OUT;
            end
         end
         S_GDIV: begin
            dvd_in  = {dvd_ff[DVD_BITS-2:0], d_ge};
            drem_in = d_ge ? d_diff[DVS_BITS-1:0] : d_sh[DVS_BITS-1:0];
            cnt_in  = cnt_ff + 7'd1;
            if (cnt_ff == DIV_LAST) begin
               grav_in  = q_sat(dvd_in, dvs_ff);
               state_in = (above_ff >= 17'(cfg.min_samples)) ? S_MUL1 : S_OUT;
            end
         end
         S_MUL1: begin
            prod_in  = 32'(cfg.sensitivity_lsb_per_g) * 32'(cfg.sensitivity_lsb_per_g);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            dvd_in   = {dnum, 16'(0)};
            dvs_in   = sq_ff;
            drem_in  = '0;
            cnt_in   = '0;
            state_in = S_DDIV;
         end
         S_DDIV: begin
            dvd_in  = {dvd_ff[DVD_BITS-2:0], d_ge};
            drem_in = d_ge ? d_diff[DVS_BITS-1:0] : d_sh[DVS_BITS-1:0];
            cnt_in  = cnt_ff + 7'd1;
            if (cnt_ff == DIV_LAST) begin
               dci_in    = q_sat(dvd_in, dvs_ff);
               dvalid_in = 1'b1;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            // hand the result over once the output register is free
            if (!ovalid_ff || pop) begin
               out_in.status        = status_ff;
               out_in.valid_count   = valid_ff;
               out_in.above_count   = above_ff;
               out_in.gravity_g     = grav_ff;
               out_in.comfort_index = dci_ff;
               out_in.dci_valid     = dvalid_ff;
               ovalid_in            = 1'b1;
               win_in               = '0;
               valid_in             = '0;
               above_in             = '0;
               mag_in               = '0;
               sq_in                = '0;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and window state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         win_ff    <= '0;
         valid_ff  <= '0;
         above_ff  <= '0;
         mag_ff    <= '0;
         sq_ff     <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         win_ff    <= win_in;
         valid_ff  <= valid_in;
         above_ff  <= above_in;
         mag_ff    <= mag_in;
         sq_ff     <= sq_in;
         ovalid_ff <= ovalid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      last_ff   <= last_in;
      cnt_ff    <= cnt_in;
      ssq_ff    <= ssq_in;
      root_ff   <= root_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
      dvs_ff    <= dvs_in;
      drem_ff   <= drem_in;
      prod_ff   <= prod_in;
      status_ff <= status_in;
      grav_ff   <= grav_in;
      dci_ff    <= dci_in;
      dvalid_ff <= dvalid_in;
      out_ff    <= out_in;
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import dci_pkg::*;

   localparam int CYCLE_LIMIT = 20000;

   logic        clock;
   logic        reset;
   req_type     req_data;
   logic        push;
   logic        full;
   rsp_type     rsp_data;
   logic        empty;
   logic        pop;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   dynamic_comfort_index_window uut (
      .clock(clock), .reset(reset), .req_data(req_data), .push(push), .full(full),
      .rsp_data(rsp_data), .empty(empty), .pop(pop), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Predictor state
   logic [15:0] sens_q;
   logic [14:0] thr_q;
   logic [15:0] minimum_q;
   logic [16:0] win_cnt;
   logic [16:0] valid_cnt;
   logic [16:0] above_cnt;
   logic [32:0] mag_acc;
   logic [46:0] sq_acc;

   rsp_type     pending_results[$];
   int          fail_count;
   int          idle_cycles;
   bit          quiet_tail;
   bit          hold_off;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [16:0] iroot(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      logic [63:0] rem;
      res = 0;
      rem = n;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res[16:0];
   endfunction

   function automatic logic [31:0] fix_div(input logic [79:0] num, input logic [79:0] den);
      logic [95:0] q;
      if (den == 0) return 32'hFFFF_FFFF;
      q = {num, 16'd0} / den;
      if (q > 96'hFFFF_FFFF) return 32'hFFFF_FFFF;
      return q[31:0];
   endfunction

   function automatic logic [15:0] abs_axis(input logic signed [15:0] v);
      logic [16:0] r;
      r = v[15] ? 17'h10000 - {1'b0, v} : {1'b0, v};
      return r[15:0] == 0 && v[15] ? 16'h8000 : r[15:0];
   endfunction

   // Advance the window by one sample; queue a result when it closes
   task automatic predict_comfort(input req_type s);
      logic [15:0] ax, ay, az;
      logic [16:0] mag;
      logic [63:0] sum;
      rsp_type     r;
      if (win_cnt < CNT_CAP) begin
         win_cnt++;
         if (s.sample_valid) begin
            ax = abs_axis(s.accel_x);
            ay = abs_axis(s.accel_y);
            az = abs_axis(s.accel_z);
            mag = iroot(64'(ax) * ax + 64'(ay) * ay + 64'(az) * az);
            mag_acc = (34'(mag_acc) + mag > 34'(MAG_MAX)) ? MAG_MAX : mag_acc + mag;
            valid_cnt++;
            if (ax > thr_q) begin
               sq_acc = (48'(sq_acc) + 32'(ax) * ax > 48'(SQ_MAX)) ? SQ_MAX
                        : sq_acc + 32'(ax) * ax;
               above_cnt++;
            end
         end
      end
      if (!s.last_sample) return;
      r = '0;
      if (win_cnt < minimum_q) r.status = ST_SHORT;
      else if (valid_cnt < minimum_q) r.status = ST_FEW;
      else r.status = ST_OK;
      r.valid_count = valid_cnt;
      r.above_count = above_cnt;
      if (r.status == ST_OK) begin
         r.gravity_g = fix_div(mag_acc, 80'(valid_cnt) * sens_q);
         if (above_cnt >= minimum_q) begin
            r.dci_valid = 1'b1;
            r.comfort_index = fix_div(80'(above_cnt) * sens_q * sens_q, sq_acc);
         end
      end
      pending_results.push_back(r);
      win_cnt = 0;
      valid_cnt = 0;
      above_cnt = 0;
      mag_acc = 0;
      sq_acc = 0;
   endtask

   // Offer one sample; push stays high into the next call unless a gap follows
   task automatic send_sample(input req_type s, input bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_data <= s;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_comfort(s);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_SENS: sens_q = val[15:0];
         REG_THR:  thr_q = val[14:0];
         default:  minimum_q = val[15:0];
      endcase
      @(negedge clock);
   endtask

   // Wait for the block to drain before touching registers
   task automatic wait_idle();
      push <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   function automatic req_type rand_sample(input bit want_last);
      req_type s;
      s.accel_x = 16'($urandom);
      s.accel_y = 16'($urandom);
      s.accel_z = 16'($urandom);
      s.sample_valid = $urandom_range(0, 7) != 0;
      s.last_sample = want_last;
      return s;
   endfunction

   // Result checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && pop && !empty) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_data.status !== e.status)
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_data.status);
            if (rsp_data.valid_count !== e.valid_count)
               $display("%0t: valid_count expected %0d actual %0d", $time, e.valid_count,
                        rsp_data.valid_count);
            if (rsp_data.above_count !== e.above_count)
               $display("%0t: above_count expected %0d actual %0d", $time, e.above_count,
                        rsp_data.above_count);
            if (rsp_data.gravity_g !== e.gravity_g)
               $display("%0t: gravity_g expected %h actual %h", $time, e.gravity_g,
                        rsp_data.gravity_g);
            if (rsp_data.comfort_index !== e.comfort_index)
               $display("%0t: comfort_index expected %h actual %h", $time, e.comfort_index,
                        rsp_data.comfort_index);
            if (rsp_data.dci_valid !== e.dci_valid)
               $display("%0t: dci_valid expected %b actual %b", $time, e.dci_valid,
                        rsp_data.dci_valid);
            if (rsp_data !== e) fail_count++;
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off
   initial begin
      int n;
      pop = 1'b0;
      @(negedge clock);
      while (1) begin
         @(negedge clock);
         if (hold_off) begin
            pop <= 1'b0;
            for (n = 0; n < 3000; n++) @(negedge clock);
            hold_off = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         pop <= 1'b1;
      end
   end

   // Watchdog: cycles without any transfer
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   typedef struct {
      req_type s;
      bit      known;
      rsp_type r;
   } stim_row;

   initial begin
      stim_row rows[$];
      stim_row row;
      req_type s;
      int      i, k, wlen;
      fail_count = 0;
      idle_cycles = 0;
      quiet_tail = 0;
      hold_off = 0;
      reset = 1'b1;
      push = 1'b0;
      req_data = '0;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      sens_q = 16'd16384; thr_q = 15'd16384; minimum_q = 16'd10;
      win_cnt = 0; valid_cnt = 0; above_cnt = 0; mag_acc = 0; sq_acc = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: a lone sample ends a too-short window
      row.s = '{accel_x: 16'sh7FFF, accel_y: 16'sh7FFF, accel_z: 16'sh7FFF,
                sample_valid: 1, last_sample: 1};
      row.known = 1;
      row.r = '{status: ST_SHORT, valid_count: 1, above_count: 1, gravity_g: 0,
                comfort_index: 0, dci_valid: 0};
      rows.push_back(row);
      // Window of ten invalid samples: too few valid
      for (i = 0; i < 10; i++) begin
         row.s = '{accel_x: 16'sh8000, accel_y: 0, accel_z: 0, sample_valid: 0,
                   last_sample: i == 9};
         row.known = (i == 9);
         row.r = '{status: ST_FEW, valid_count: 0, above_count: 0, gravity_g: 0,
                   comfort_index: 0, dci_valid: 0};
         rows.push_back(row);
      end
      // Ten most negative X samples: magnitude 2^15, gravity 2.0 g, DCI 0.25
      for (i = 0; i < 10; i++) begin
         row.s = '{accel_x: 16'sh8000, accel_y: 0,
                   accel_z: 0, sample_valid: 1, last_sample: i == 9};
         row.known = 0;
         rows.push_back(row);
      end
      // Typed expectations replace the predicted result of their window
      for (i = 0; i < rows.size(); i++) begin
         send_sample(rows[i].s, 1'b0);
         if (rows[i].known && rows[i].s.last_sample) begin
            void'(pending_results.pop_back());
            pending_results.push_back(rows[i].r);
         end
      end

      // Random phases under various register settings, extremes included
      for (k = 0; k < 6; k++) begin
         wait_idle();
         case (k)
            0: begin csr_write(REG_SENS, 1); csr_write(REG_THR, 0); csr_write(REG_MIN, 1); end
            1: begin csr_write(REG_SENS, 32768); csr_write(REG_THR, 32767);
                     csr_write(REG_MIN, 2); end
            2: begin csr_write(REG_SENS, $urandom_range(1, 32768));
                     csr_write(REG_THR, $urandom_range(0, 32767));
                     csr_write(REG_MIN, $urandom_range(1, 6)); end
            3: begin csr_write(REG_SENS, 16'hFFFF); csr_write(REG_THR, 15'h7FFF);
                     csr_write(REG_MIN, 16'hFFFF); end
            4: begin csr_write(REG_SENS, 4096); csr_write(REG_THR, $urandom_range(0, 20000));
                     csr_write(REG_MIN, 3); end
            default: begin csr_write(REG_SENS, 0); csr_write(REG_THR, 0);
                     csr_write(REG_MIN, 1); end
         endcase
         if (k == 1) hold_off = 1'b1;
         if (k == 5) quiet_tail = 1'b1;
         for (i = 0; i < 85; ) begin
            wlen = $urandom_range(1, 8);
            for (int j = 0; j < wlen; j++, i++) begin
               s = rand_sample(j == wlen - 1);
               send_sample(s, !quiet_tail);
            end
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
